>>> rtl/prs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prs_pkg
// Shared widths, register map, command codes and types of the rate selector.
// ----------------------------------------------------------------------------
package prs_pkg;

    localparam int NUM_RATES_DEF = 4;
    localparam int PULSE_W       = 12;
    localparam int THR_W         = 12;
    localparam int RPM_W         = 16;
    localparam int ENTRY_W       = THR_W + RPM_W;
    localparam int IDX_W         = 3;
    localparam int CMD_W         = 2;
    localparam int ACTIVE_W      = 3;
    localparam int APB_DATA_W    = 32;
    localparam int HYST_US       = 50;
    localparam int CMP_W         = THR_W + 2;

    localparam int REG_ACTIVE    = 0;
    localparam int REG_ENTRY0    = 1;

    localparam logic signed [IDX_W-1:0] IDLE_INDEX = '1;

    typedef enum logic [CMD_W-1:0] {
        CMD_NONE = 2'd0,
        CMD_ON   = 2'd1,
        CMD_OFF  = 2'd2
    } t_cmd;

    typedef struct packed {
        logic             found;
        logic [IDX_W-1:0] idx;
        logic [RPM_W-1:0] rpm;
    } t_pick;

endpackage

>>> rtl/prs_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prs_if
// Valid/ready channels for pulse samples and rate selection results.
// ----------------------------------------------------------------------------
interface prs_in_if;
    logic                        valid;
    logic                        ready;
    logic [prs_pkg::PULSE_W-1:0] pulse_width;

    modport source (output valid, output pulse_width, input ready);
    modport sink   (input valid, input pulse_width, output ready);
endinterface

interface prs_out_if;
    logic                             valid;
    logic                             ready;
    logic signed [prs_pkg::IDX_W-1:0] sel_index;
    logic                             firing;
    logic [prs_pkg::RPM_W-1:0]        rpm;
    logic [prs_pkg::CMD_W-1:0]        command;

    modport source (output valid, output sel_index, output firing, output rpm,
                    output command, input ready);
    modport sink   (input valid, input sel_index, input firing, input rpm,
                    input command, output ready);
endinterface

>>> rtl/prs_cfg_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prs_cfg_regs
// APB register file holding the active entry count and the rate entries.
// ----------------------------------------------------------------------------
module prs_cfg_regs #(
    parameter int NUM_RATES = prs_pkg::NUM_RATES_DEF,
    parameter int PADDR_W   = $clog2(4 * (NUM_RATES + 1)),
    parameter int CNT_W     = $clog2(NUM_RATES + 1)
) (
    input  logic                                              i_clk,
    input  logic                                              i_rst_n,
    input  logic                                              psel,
    input  logic                                              penable,
    input  logic                                              pwrite,
    input  logic [PADDR_W-1:0]                                paddr,
    input  logic [prs_pkg::APB_DATA_W-1:0]                    pwdata,
    output logic [prs_pkg::APB_DATA_W-1:0]                    prdata,
    output logic                                              pready,
    output logic [CNT_W-1:0]                                  o_count,
    output logic [NUM_RATES-1:0][prs_pkg::ENTRY_W-1:0]        o_entries
);
    import prs_pkg::*;

    localparam int AIDX_W = PADDR_W - 2;

    logic [ACTIVE_W-1:0]                r_active;
    logic [NUM_RATES-1:0][ENTRY_W-1:0]  r_entry;
    logic [AIDX_W-1:0]                  reg_idx;
    logic                               wr_en;

    assign reg_idx = paddr[PADDR_W-1:2];
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= '0;
            r_entry  <= '0;
        end else if (wr_en) begin
            if (reg_idx == AIDX_W'(REG_ACTIVE)) begin
                r_active <= pwdata[ACTIVE_W-1:0];
            end
            for (int k = 0; k < NUM_RATES; k++) begin
                if (reg_idx == AIDX_W'(REG_ENTRY0 + k)) begin
                    r_entry[k] <= pwdata[ENTRY_W-1:0];
                end
            end
        end
    end

    always_comb begin
        prdata = '0;
        if (reg_idx == AIDX_W'(REG_ACTIVE)) begin
            prdata = APB_DATA_W'(r_active);
        end
        for (int k = 0; k < NUM_RATES; k++) begin
            if (reg_idx == AIDX_W'(REG_ENTRY0 + k)) begin
                prdata = APB_DATA_W'(r_entry[k]);
            end
        end
    end

    // Counts above the number of entries are clamped.
    assign o_count   = ({1'b0, r_active} > (ACTIVE_W + 1)'(NUM_RATES)) ?
                       CNT_W'(NUM_RATES) : CNT_W'(r_active);
    assign o_entries = r_entry;

endmodule

>>> rtl/prs_select.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prs_select
// Threshold scan with hysteresis that picks the rate entry for one pulse.
// ----------------------------------------------------------------------------
module prs_select #(
    parameter int NUM_RATES = prs_pkg::NUM_RATES_DEF,
    parameter int CNT_W     = $clog2(NUM_RATES + 1)
) (
    input  logic [prs_pkg::PULSE_W-1:0]                i_pulse_width,
    input  logic                                       i_prev_valid,
    input  logic [prs_pkg::IDX_W-1:0]                  i_prev_idx,
    input  logic [CNT_W-1:0]                           i_count,
    input  logic [NUM_RATES-1:0][prs_pkg::ENTRY_W-1:0] i_entries,
    output prs_pkg::t_pick                             o_pick
);
    import prs_pkg::*;

    always_comb begin : scan
        logic                     stop;
        logic [THR_W-1:0]         best_thr;
        logic [THR_W-1:0]         thr;
        logic [THR_W-1:0]         next_thr;
        logic                     is_cur;
        logic signed [CMP_W-1:0]  eff;
        logic signed [CMP_W-1:0]  pulse_s;

        stop     = 1'b0;
        best_thr = '0;
        o_pick   = '0;
        pulse_s  = $signed(CMP_W'(i_pulse_width));
        for (int i = 0; i < NUM_RATES; i++) begin
            thr      = i_entries[i][THR_W-1:0];
            next_thr = i_entries[(i + 1 < NUM_RATES) ? i + 1 : i][THR_W-1:0];
            is_cur   = i_prev_valid && (i_prev_idx == IDX_W'(i));
            eff      = is_cur ? $signed(CMP_W'(thr)) - CMP_W'(HYST_US)
                              : $signed(CMP_W'(thr)) + CMP_W'(HYST_US);
            if (!stop && (CNT_W'(i) < i_count)) begin
                if (pulse_s >= eff) begin
                    if (!o_pick.found || (thr > best_thr)) begin
                        o_pick.found = 1'b1;
                        o_pick.idx   = IDX_W'(i);
                        o_pick.rpm   = i_entries[i][ENTRY_W-1:THR_W];
                        best_thr     = thr;
                    end
                end else if (!is_cur && ((i + 1) < int'(i_count))) begin
                    if (next_thr > thr) begin
                        stop = 1'b1;
                    end
                end
            end
        end
    end

endmodule

>>> rtl/pwm_rate_selector_hysteresis_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pwm_rate_selector_hysteresis_core
// Picks a rate entry for each averaged pulse width and reports changes.
//
// Channel   Direction  Transaction
// i_in      sink       one pulse_width sample
// o_out     source     sel_index, firing, rpm, command
// APB       slave      write or read of one configuration register
//
// A sample accepted into the input register is scanned combinationally and
// written to the result register once that register is empty or its result is
// taken, and one sample can be accepted every cycle while results are taken.
// Reset clears the selection to idle, the configuration registers to zero and
// both valid flags. A stalled result holds the pipeline in place.
// ----------------------------------------------------------------------------
module pwm_rate_selector_hysteresis_core #(
    parameter int NUM_RATES = prs_pkg::NUM_RATES_DEF,
    parameter int PADDR_W   = $clog2(4 * (NUM_RATES + 1))
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    prs_in_if.sink                         i_in,
    prs_out_if.source                      o_out,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [PADDR_W-1:0]             paddr,
    input  logic [prs_pkg::APB_DATA_W-1:0] pwdata,
    output logic [prs_pkg::APB_DATA_W-1:0] prdata,
    output logic                           pready
);
    import prs_pkg::*;

    localparam int CNT_W = $clog2(NUM_RATES + 1);

    logic [CNT_W-1:0]                  count;
    logic [NUM_RATES-1:0][ENTRY_W-1:0] entries;
    t_pick                             pick;
    t_cmd                              cmd;
    logic                              advance;

    logic                              r_in_valid;
    logic [PULSE_W-1:0]                r_pulse;
    logic                              r_out_valid;
    logic                              n_out_valid;
    logic signed [IDX_W-1:0]           r_sel_index;
    logic                              r_firing;
    logic [RPM_W-1:0]                  r_rpm;
    t_cmd                              r_cmd;
    logic                              r_sel_valid;
    logic [IDX_W-1:0]                  r_sel_idx;

    prs_cfg_regs #(
        .NUM_RATES (NUM_RATES),
        .PADDR_W   (PADDR_W),
        .CNT_W     (CNT_W)
    ) u_cfg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .o_count   (count),
        .o_entries (entries)
    );

    prs_select #(
        .NUM_RATES     (NUM_RATES),
        .CNT_W         (CNT_W)
    ) u_select (
        .i_pulse_width (r_pulse),
        .i_prev_valid  (r_sel_valid),
        .i_prev_idx    (r_sel_idx),
        .i_count       (count),
        .i_entries     (entries),
        .o_pick        (pick)
    );

    assign advance    = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_in_valid || advance;

    always_comb begin
        if ((pick.found != r_sel_valid) || (pick.found && (pick.idx != r_sel_idx))) begin
            cmd = pick.found ? CMD_ON : CMD_OFF;
        end else begin
            cmd = CMD_NONE;
        end
        if (advance) begin
            n_out_valid = 1'b1;
        end else if (o_out.ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_sel_valid <= 1'b0;
            r_sel_idx   <= '0;
        end else begin
            if (i_in.ready) begin
                r_in_valid <= i_in.valid;
            end
            r_out_valid <= n_out_valid;
            if (advance) begin
                r_sel_valid <= pick.found;
                r_sel_idx   <= pick.idx;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.ready && i_in.valid) begin
            r_pulse <= i_in.pulse_width;
        end
        if (advance) begin
            r_sel_index <= pick.found ? $signed(pick.idx) : IDLE_INDEX;
            r_firing    <= pick.found;
            r_rpm       <= pick.found ? pick.rpm : '0;
            r_cmd       <= cmd;
        end
    end

    assign o_out.valid     = r_out_valid;
    assign o_out.sel_index = r_sel_index;
    assign o_out.firing    = r_firing;
    assign o_out.rpm       = r_rpm;
    assign o_out.command   = r_cmd;

`ifndef SYNTHESIS
    a_on_firing : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && (o_out.command == CMD_ON)) |-> o_out.firing)
        else $error("Trigger-on transaction reported while not firing.");

    a_off_idle : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && (o_out.command == CMD_OFF)) |-> !o_out.firing)
        else $error("Trigger-off transaction reported while firing.");

    a_state_tracks : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(advance && i_rst_n) |-> (r_sel_valid == o_out.firing))
        else $error("Held selection disagrees with the last result.");

    a_in_hold : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !advance) |=> (r_in_valid && $stable(r_pulse)))
        else $error("Pending sample lost while the result was stalled.");
`endif

endmodule

>>> tb/pwm_rate_selector_hysteresis_core_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pwm_rate_selector_hysteresis_core_test
// Self-checking bench for the rate selector with hysteresis.
//
// Pulse samples go in on a valid/ready channel while results are taken with
// random stalls. A tracker class keeps its own copy of the rate entries and
// of the held selection, works out the expected index, firing flag, rpm and
// command for every accepted sample, and checks each result transaction in
// order. A directed part covers empty and oversized counts, the hysteresis
// band, the early stop of the scan, stale selections and equal thresholds.
// Random phases with fresh settings and sweeps across the thresholds follow.
// Register writes go through the APB port while the block is idle; after each
// full load of the table the registers are read back.
// ----------------------------------------------------------------------------
module pwm_rate_selector_hysteresis_core_test;
    import prs_pkg::*;

    localparam int N_ENTRIES  = NUM_RATES_DEF;
    localparam int ADDR_W     = $clog2(4 * (N_ENTRIES + 1));
    localparam int LAST_INDEX = (1 << ADDR_W) / 4 - 1;
    localparam bit APB_WRITE  = 1'b1;
    localparam bit APB_READ   = 1'b0;

    typedef struct {
        logic signed [IDX_W-1:0] sel_index;
        logic                    firing;
        logic [RPM_W-1:0]        rpm;
        t_cmd                    command;
    } t_rate_result;

    class rate_selection_tracker;
        logic [ACTIVE_W-1:0] active_count;
        logic [ENTRY_W-1:0]  entries [N_ENTRIES];
        int                  held_rate;
        t_rate_result        pending_selections [$];
        int unsigned         errors;

        function new();
            active_count = '0;
            foreach (entries[k]) entries[k] = '0;
            held_rate = -1;
            errors = 0;
        endfunction

        function void write_reg(int idx, logic [APB_DATA_W-1:0] data);
            if (idx == REG_ACTIVE) begin
                active_count = data[ACTIVE_W-1:0];
            end else if (idx >= REG_ENTRY0 && idx < REG_ENTRY0 + N_ENTRIES) begin
                entries[idx - REG_ENTRY0] = data[ENTRY_W-1:0];
            end
        endfunction

        function logic [APB_DATA_W-1:0] reg_value(int idx);
            if (idx == REG_ACTIVE) return APB_DATA_W'(active_count);
            return APB_DATA_W'(entries[idx - REG_ENTRY0]);
        endfunction

        function int threshold(int k);
            return int'(entries[k][THR_W-1:0]);
        endfunction

        function int pick_rate_entry(int pulse);
            int count;
            int best;
            int best_thr;
            int thr;
            int adj;
            int i;
            bit scanning;
            count = (active_count > N_ENTRIES) ? N_ENTRIES : int'(active_count);
            best = -1;
            best_thr = -1;
            scanning = 1'b1;
            for (i = 0; i < count && scanning; i++) begin
                thr = threshold(i);
                adj = (i == held_rate) ? thr - HYST_US : thr + HYST_US;
                if (pulse >= adj) begin
                    if (thr > best_thr) begin
                        best_thr = thr;
                        best = i;
                    end
                end else if (i != held_rate && i + 1 < count) begin
                    if (threshold(i + 1) > thr) scanning = 1'b0;
                end
            end
            return best;
        endfunction

        function void note_pulse(logic [PULSE_W-1:0] pulse);
            t_rate_result want;
            int next;
            next = pick_rate_entry(int'(pulse));
            want.command = CMD_NONE;
            if (next != held_rate) want.command = (next >= 0) ? CMD_ON : CMD_OFF;
            held_rate = next;
            want.sel_index = IDX_W'(next);
            want.firing = (next >= 0);
            want.rpm = (next >= 0) ? entries[next][ENTRY_W-1:THR_W] : '0;
            pending_selections.push_back(want);
        endfunction

        function int pending();
            return pending_selections.size();
        endfunction

        task report_mismatch(string what, int got, int want);
            errors++;
            if (errors <= 40) begin
                $display("%0t ns: mismatch in %s: got %0d, expected %0d", $time, what, got, want);
            end
        endtask

        task check_selection(logic signed [IDX_W-1:0] idx, logic firing,
                             logic [RPM_W-1:0] rpm, logic [CMD_W-1:0] command);
            t_rate_result want;
            if (pending_selections.size() == 0) begin
                report_mismatch("result without a pending sample, sel_index", int'(idx), -1);
                return;
            end
            want = pending_selections.pop_front();
            if (idx !== want.sel_index) begin
                report_mismatch("sel_index", int'(idx), int'(want.sel_index));
            end
            if (firing !== want.firing) report_mismatch("firing", int'(firing), int'(want.firing));
            if (rpm !== want.rpm) report_mismatch("rpm", int'(rpm), int'(want.rpm));
            if (command !== want.command) begin
                report_mismatch("command", int'(command), int'(want.command));
            end
        endtask
    endclass

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [ADDR_W-1:0]     paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;
    bit                    no_gaps;
    rate_selection_tracker tracker;

    prs_in_if  in_bus ();
    prs_out_if out_bus ();

    pwm_rate_selector_hysteresis_core u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_bus),
        .o_out   (out_bus),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("** pwm_rate_selector_hysteresis_core: FAILED **");
        $finish;
    end

    function int draw_gap();
        return no_gaps ? 0 : int'($urandom_range(0, 8));
    endfunction

    function logic [PULSE_W-1:0] draw_pulse();
        int p;
        case ($urandom_range(0, 9))
            0, 1: begin
                p = int'($urandom_range(0, 4095));
            end
            2: begin
                p = $urandom_range(0, 1) ? 4095 : 0;
            end
            default: begin
                p = tracker.threshold(int'($urandom_range(0, N_ENTRIES - 1)))
                    + int'($urandom_range(0, 140)) - 70;
            end
        endcase
        if (p < 0) p = 0;
        if (p > 4095) p = 4095;
        return PULSE_W'(p);
    endfunction

    task send_pulse(logic [PULSE_W-1:0] pulse);
        int gap;
        gap = draw_gap();
        if (gap > 0) begin
            in_bus.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_bus.valid <= 1'b1;
        in_bus.pulse_width <= pulse;
        @(posedge i_clk);
        while (!in_bus.ready) @(posedge i_clk);
        tracker.note_pulse(pulse);
    endtask

    task sweep_pulses();
        int p;
        int step;
        int n;
        p = int'(draw_pulse());
        step = int'($urandom_range(5, 40));
        if ($urandom_range(0, 1)) step = -step;
        for (n = 0; n < 8; n++) begin
            if (p < 0) p = 0;
            if (p > 4095) p = 4095;
            send_pulse(PULSE_W'(p));
            p += step;
        end
    endtask

    task settle();
        in_bus.valid <= 1'b0;
        while (tracker.pending() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task apb_access(bit is_write, int idx, logic [APB_DATA_W-1:0] data);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= is_write;
        paddr <= ADDR_W'(4 * idx);
        pwdata <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        if (is_write) begin
            tracker.write_reg(idx, data);
        end else if (prdata !== tracker.reg_value(idx)) begin
            tracker.report_mismatch($sformatf("readback of register %0d", idx),
                                    int'(prdata), int'(tracker.reg_value(idx)));
        end
        psel <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task read_back_all();
        int k;
        for (k = 0; k <= N_ENTRIES; k++) apb_access(APB_READ, k, '0);
    endtask

    task load_entry(int k, int thr, int rpm);
        apb_access(APB_WRITE, REG_ENTRY0 + k, APB_DATA_W'({RPM_W'(rpm), THR_W'(thr)}));
    endtask

    task shuffle_rates();
        int style;
        int thr;
        int rpm;
        int k;
        int n;
        style = int'($urandom_range(0, 3));
        thr = int'($urandom_range(0, 800));
        for (k = 0; k < N_ENTRIES; k++) begin
            case (style)
                0: begin
                    thr += int'($urandom_range(0, 1200));
                end
                1: begin
                    thr = int'($urandom_range(0, 4095));
                end
                2: begin
                    case ($urandom_range(0, 4))
                        0: thr = 0;
                        1: thr = 4095;
                        2: thr = HYST_US;
                        3: thr = 4095 - HYST_US;
                        default: thr = thr;
                    endcase
                end
                default: begin
                    thr += int'($urandom_range(0, 120));
                end
            endcase
            if (thr > 4095) thr = 4095;
            case ($urandom_range(0, 5))
                0: rpm = 0;
                1: rpm = 65535;
                default: rpm = int'($urandom_range(0, 65535));
            endcase
            if ($urandom_range(0, 4) != 0) load_entry(k, thr, rpm);
        end
        n = int'($urandom_range(0, 11));
        if (n > 9) n = int'($urandom_range(N_ENTRIES + 1, 7));
        else if (n > 0) n = (n - 1) % N_ENTRIES + 1;
        apb_access(APB_WRITE, REG_ACTIVE, APB_DATA_W'(n));
        if ($urandom_range(0, 3) == 0) begin
            apb_access(APB_WRITE, int'($urandom_range(N_ENTRIES + 1, LAST_INDEX)),
                       APB_DATA_W'($urandom_range(0, 28'hFFF_FFFF)));
        end
        read_back_all();
    endtask

    initial begin
        int stall;
        out_bus.ready <= 1'b0;
        @(posedge i_clk);
        while (i_rst_n !== 1'b1) @(posedge i_clk);
        forever begin
            stall = draw_gap();
            if (stall > 0) begin
                out_bus.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            out_bus.ready <= 1'b1;
            @(posedge i_clk);
            while (!out_bus.valid) @(posedge i_clk);
            tracker.check_selection(out_bus.sel_index, out_bus.firing, out_bus.rpm,
                                    out_bus.command);
        end
    end

    initial begin
        int k;
        int phase;
        int sent;
        tracker = new();
        no_gaps = 1'b0;
        i_rst_n <= 1'b0;
        in_bus.valid <= 1'b0;
        in_bus.pulse_width <= '0;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= '0;
        pwdata <= '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Out of reset no entry is in use, so nothing can fire.
        send_pulse(0);
        send_pulse(4095);
        settle();

        load_entry(0, 1000, 1200);
        load_entry(1, 2000, 2400);
        load_entry(2, 3000, 65535);
        load_entry(3, 4095, 0);
        for (k = N_ENTRIES + 1; k <= LAST_INDEX; k++) begin
            apb_access(APB_WRITE, k, APB_DATA_W'(28'hFFF_FFFF));
        end
        apb_access(APB_WRITE, REG_ACTIVE, N_ENTRIES);
        read_back_all();
        send_pulse(1049);
        send_pulse(1050);
        send_pulse(960);
        send_pulse(949);
        send_pulse(2100);
        send_pulse(4095);
        send_pulse(2960);
        send_pulse(0);
        settle();

        // A count above the number of entries is clamped.
        apb_access(APB_WRITE, REG_ACTIVE, 7);
        send_pulse(4095);
        send_pulse(1100);
        settle();

        apb_access(APB_WRITE, REG_ACTIVE, 0);
        send_pulse(3000);
        send_pulse(4095);
        settle();

        // The held entry drops out of the scan, then its rpm is rewritten.
        apb_access(APB_WRITE, REG_ACTIVE, N_ENTRIES);
        send_pulse(3100);
        settle();
        apb_access(APB_WRITE, REG_ACTIVE, 2);
        load_entry(2, 100, 7);
        send_pulse(2030);
        send_pulse(2060);
        settle();
        load_entry(1, 2000, 4321);
        send_pulse(2000);
        settle();

        // Equal thresholds resolve to the lowest index.
        load_entry(0, 0, 0);
        load_entry(1, 0, 65535);
        load_entry(2, 0, 1);
        load_entry(3, 0, 2);
        apb_access(APB_WRITE, REG_ACTIVE, N_ENTRIES);
        read_back_all();
        send_pulse(49);
        send_pulse(50);
        send_pulse(0);

        for (phase = 0; phase < 12; phase++) begin
            settle();
            shuffle_rates();
            no_gaps = ($urandom_range(0, 3) == 0);
            sent = 0;
            while (sent < 100) begin
                if ($urandom_range(0, 3) == 0) begin
                    sweep_pulses();
                    sent += 8;
                end else begin
                    send_pulse(draw_pulse());
                    sent++;
                end
            end
        end
        settle();
        repeat (8) @(posedge i_clk);

        if (tracker.errors == 0) begin
            $display("** pwm_rate_selector_hysteresis_core: PASSED **");
        end else begin
            $display("** pwm_rate_selector_hysteresis_core: FAILED **");
        end
        $finish;
    end

endmodule
